>>> sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PSP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/psp_pkg.sv
// shared constants for the point to segment proximity block
`timescale 1ns / 1ps
package psp_pkg;
  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int THR_W          = 32;
  localparam int ZTOL_W         = 19;
  localparam int REG_IDX_W      = 2;
  localparam logic [THR_W-1:0]  THR_RESET  = 32'd256;
  localparam logic [ZTOL_W-1:0] ZTOL_RESET = 19'd160;
  localparam logic [REG_IDX_W-1:0] REG_DIST_THR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_Z_TOL    = 2'd1;
endpackage

>>> sv/psp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psp_div #(
  parameter int NW = 2 * psp_pkg::COORD_BITS_DEF + 2,
  parameter int QW = psp_pkg::FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);
  import psp_pkg::*;

  logic          pv   [QW+1];
  logic          rdy  [QW+1];
  logic [NW-1:0] prem [QW+1];
  logic [NW-1:0] pdn  [QW+1];
  logic [QW-1:0] pq   [QW+1];
  logic [SW-1:0] psd  [QW+1];

  assign pv[0]   = in_valid;
  assign prem[0] = num;
  assign pdn[0]  = den;
  assign pq[0]   = '0;
  assign psd[0]  = side_in;
  assign rdy[QW] = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW:0] trial;
    assign rdy[k] = !pv[k+1] || rdy[k+1];
    assign trial  = {prem[k], 1'b0} - {1'b0, pdn[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        pv[k+1] <= pv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && pv[k]) begin
        pdn[k+1] <= pdn[k];
        psd[k+1] <= psd[k];
        if (!trial[NW]) begin
          prem[k+1] <= trial[NW-1:0];
          pq[k+1]   <= {pq[k][QW-2:0], 1'b1};
        end else begin
          prem[k+1] <= {prem[k][NW-2:0], 1'b0};
          pq[k+1]   <= {pq[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = pv[QW];
  assign quo       = pq[QW];
  assign side_out  = psd[QW];

  `PSP_ASSERT_IMPL(a_rem_below_den, clk, rst, pv[QW] && (pdn[QW] != '0), prem[QW] < pdn[QW])
  `PSP_ASSERT_NEXT(a_last_holds, clk, rst, pv[QW] && !out_ready, pv[QW])
  `PSP_ASSERT_NEXT(a_last_kept, clk, rst, pv[QW] && !out_ready, $stable(pq[QW]) && $stable(psd[QW]))
endmodule

>>> sv/point_segment_proximity.sv
// top level of the point to segment proximity block
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Tests a point against the current waypoint and against the segment from the
// previous waypoint, one word per clock cycle sustained while the output is
// not stalled. The path is four front stages (differences, products, sums,
// range checks), a FRAC_BITS-stage divider that makes the projection
// fraction one bit per stage, and five back stages (interpolation product,
// rounding, offset, squares, final compare, which is the output register).
// Valid bits travel with every stage and each stage has its own ready, so
// bubbles close up while the output is stalled. Configuration writes go
// through the cfg port and must only be made while the block is empty.
module point_segment_proximity #(
  parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [psp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [psp_pkg::THR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  point_z,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  start_z,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic signed [COORD_BITS-1:0]  end_z,
  input  logic                          has_segment,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          match_waypoint,
  output logic                          near_segment
);
  import psp_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = C + 1;        // coordinate difference
  localparam int LW  = 2 * DW;       // product / squared length
  localparam int TW  = LW + 2;       // dot product sum
  localparam int MW  = F + 1 + DW;   // fraction times delta
  localparam int IW  = C + 3;        // interpolated point and offset
  localparam int QW2 = 2 * IW;       // squared offset
  localparam logic [F:0]    ONE = {1'b1, {F{1'b0}}};
  localparam logic [MW-1:0] RND = MW'((64'd1 << F) - 64'd1);

  typedef struct packed {
    logic signed [DW-1:0] dx, dy, dz;
    logic signed [C-1:0]  sx, sy, sz, px, py, pz;
    logic                 match, live, eq;
  } side_t;

  // configuration registers
  logic [THR_W-1:0]  thr;
  logic [ZTOL_W-1:0] ztol;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THR_RESET;
      ztol <= ZTOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_DIST_THR: thr  <= cfg_data;
        REG_Z_TOL:    ztol <= cfg_data[ZTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // per stage valid and ready
  logic v1, v2, v3, v4, va, vb, vc, vd, ve;
  logic r1, r2, r3, r4, ra, rb, rc, rd, re;
  logic div_ready, div_valid;

  assign re = !ve || !out_stall;
  assign rd = !vd || re;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign r4 = !v4 || div_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (ra) va <= div_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
      if (re) ve <= vd;
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] s1_mx, s1_my, s1_mz, s1_dx, s1_dy, s1_dz, s1_qx, s1_qy, s1_qz;
  logic signed [C-1:0]  s1_sx, s1_sy, s1_sz, s1_px, s1_py, s1_pz;
  logic                 s1_seg;

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_mx  <= {point_x[C-1], point_x} - {end_x[C-1], end_x};
      s1_my  <= {point_y[C-1], point_y} - {end_y[C-1], end_y};
      s1_mz  <= {point_z[C-1], point_z} - {end_z[C-1], end_z};
      s1_dx  <= {end_x[C-1], end_x} - {start_x[C-1], start_x};
      s1_dy  <= {end_y[C-1], end_y} - {start_y[C-1], start_y};
      s1_dz  <= {end_z[C-1], end_z} - {start_z[C-1], start_z};
      s1_qx  <= {point_x[C-1], point_x} - {start_x[C-1], start_x};
      s1_qy  <= {point_y[C-1], point_y} - {start_y[C-1], start_y};
      s1_qz  <= {point_z[C-1], point_z} - {start_z[C-1], start_z};
      s1_sx  <= start_x; s1_sy <= start_y; s1_sz <= start_z;
      s1_px  <= point_x; s1_py <= point_y; s1_pz <= point_z;
      s1_seg <= has_segment;
    end
  end

  // stage 2: products
  logic signed [LW-1:0] s2_mxx, s2_myy, s2_lxx, s2_lyy, s2_tx, s2_ty, s2_tz;
  logic signed [DW-1:0] s2_dx, s2_dy, s2_dz;
  logic signed [C-1:0]  s2_sx, s2_sy, s2_sz, s2_px, s2_py, s2_pz;
  logic                 s2_seg, s2_mz_ok;
  logic [DW-1:0]        mz_mag;

  assign mz_mag = s1_mz[DW-1] ? $unsigned(-s1_mz) : $unsigned(s1_mz);

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      s2_mxx   <= s1_mx * s1_mx;
      s2_myy   <= s1_my * s1_my;
      s2_lxx   <= s1_dx * s1_dx;
      s2_lyy   <= s1_dy * s1_dy;
      s2_tx    <= s1_qx * s1_dx;
      s2_ty    <= s1_qy * s1_dy;
      s2_tz    <= s1_qz * s1_dz;
      s2_mz_ok <= mz_mag <= ztol;
      s2_dx <= s1_dx; s2_dy <= s1_dy; s2_dz <= s1_dz;
      s2_sx <= s1_sx; s2_sy <= s1_sy; s2_sz <= s1_sz;
      s2_px <= s1_px; s2_py <= s1_py; s2_pz <= s1_pz;
      s2_seg <= s1_seg;
    end
  end

  // stage 3: squared length, squared distance to waypoint, dot product
  logic [LW-1:0]        s3_len, s3_msum;
  logic signed [TW-1:0] s3_dot;
  logic signed [DW-1:0] s3_dx, s3_dy, s3_dz;
  logic signed [C-1:0]  s3_sx, s3_sy, s3_sz, s3_px, s3_py, s3_pz;
  logic                 s3_seg, s3_mz_ok;

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      s3_len   <= $unsigned(s2_lxx) + $unsigned(s2_lyy);
      s3_msum  <= $unsigned(s2_mxx) + $unsigned(s2_myy);
      s3_dot   <= {{2{s2_tx[LW-1]}}, s2_tx} + {{2{s2_ty[LW-1]}}, s2_ty}
                + {{2{s2_tz[LW-1]}}, s2_tz};
      s3_mz_ok <= s2_mz_ok;
      s3_dx <= s2_dx; s3_dy <= s2_dy; s3_dz <= s2_dz;
      s3_sx <= s2_sx; s3_sy <= s2_sy; s3_sz <= s2_sz;
      s3_px <= s2_px; s3_py <= s2_py; s3_pz <= s2_pz;
      s3_seg <= s2_seg;
    end
  end

  // stage 4: range checks, divider operands
  logic [LW-1:0] s4_num, s4_len;
  side_t         s4_side;
  logic          dot_ok, len_ok, dot_eq;

  always_comb begin
    len_ok = s3_len > thr;
    dot_ok = !s3_dot[TW-1] && ($unsigned(s3_dot) <= s3_len);
    dot_eq = $unsigned(s3_dot) == s3_len;
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      s4_len        <= s3_len;
      s4_num        <= (dot_ok && !dot_eq) ? s3_dot[LW-1:0] : '0;
      s4_side.dx    <= s3_dx; s4_side.dy <= s3_dy; s4_side.dz <= s3_dz;
      s4_side.sx    <= s3_sx; s4_side.sy <= s3_sy; s4_side.sz <= s3_sz;
      s4_side.px    <= s3_px; s4_side.py <= s3_py; s4_side.pz <= s3_pz;
      s4_side.match <= s3_mz_ok && (s3_msum <= thr);
      s4_side.live  <= s3_seg && len_ok && dot_ok;
      s4_side.eq    <= dot_eq;
    end
  end

  // projection fraction
  logic [F-1:0]              d_q;
  logic [$bits(side_t)-1:0]  d_side_bits;
  side_t                     d_side;

  psp_div #(.NW(LW), .QW(F), .SW($bits(side_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .in_ready (div_ready),
    .num      (s4_num),
    .den      (s4_len),
    .side_in  (s4_side),
    .out_valid(div_valid),
    .out_ready(ra),
    .quo      (d_q),
    .side_out (d_side_bits)
  );

  assign d_side = side_t'(d_side_bits);

  // stage a: fraction times delta magnitude
  logic [F:0]          u;
  logic [DW-1:0]       ax_mag, ay_mag, az_mag;
  logic [MW-1:0]       sa_mx, sa_my, sa_mz;
  logic                sa_nx, sa_ny, sa_nz, sa_match, sa_live;
  logic signed [C-1:0] sa_sx, sa_sy, sa_sz, sa_px, sa_py, sa_pz;

  always_comb begin
    u      = d_side.eq ? ONE : {1'b0, d_q};
    ax_mag = d_side.dx[DW-1] ? $unsigned(-d_side.dx) : $unsigned(d_side.dx);
    ay_mag = d_side.dy[DW-1] ? $unsigned(-d_side.dy) : $unsigned(d_side.dy);
    az_mag = d_side.dz[DW-1] ? $unsigned(-d_side.dz) : $unsigned(d_side.dz);
  end

  always_ff @(posedge clk) begin
    if (ra && div_valid) begin
      sa_mx <= u * ax_mag; sa_my <= u * ay_mag; sa_mz <= u * az_mag;
      sa_nx <= d_side.dx[DW-1]; sa_ny <= d_side.dy[DW-1]; sa_nz <= d_side.dz[DW-1];
      sa_sx <= d_side.sx; sa_sy <= d_side.sy; sa_sz <= d_side.sz;
      sa_px <= d_side.px; sa_py <= d_side.py; sa_pz <= d_side.pz;
      sa_match <= d_side.match;
      sa_live  <= d_side.live;
    end
  end

  // stage b: interpolated point, floor toward minus infinity
  logic [MW-1:0]        tx, ty, tz;
  logic signed [IW-1:0] sb_ix, sb_iy, sb_iz;
  logic signed [C-1:0]  sb_px, sb_py, sb_pz;
  logic                 sb_match, sb_live;

  always_comb begin
    tx = (sa_nx ? sa_mx + RND : sa_mx) >> F;
    ty = (sa_ny ? sa_my + RND : sa_my) >> F;
    tz = (sa_nz ? sa_mz + RND : sa_mz) >> F;
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      sb_ix <= sa_nx ? {{3{sa_sx[C-1]}}, sa_sx} - {1'b0, tx[DW:0]}
                     : {{3{sa_sx[C-1]}}, sa_sx} + {1'b0, tx[DW:0]};
      sb_iy <= sa_ny ? {{3{sa_sy[C-1]}}, sa_sy} - {1'b0, ty[DW:0]}
                     : {{3{sa_sy[C-1]}}, sa_sy} + {1'b0, ty[DW:0]};
      sb_iz <= sa_nz ? {{3{sa_sz[C-1]}}, sa_sz} - {1'b0, tz[DW:0]}
                     : {{3{sa_sz[C-1]}}, sa_sz} + {1'b0, tz[DW:0]};
      sb_px <= sa_px; sb_py <= sa_py; sb_pz <= sa_pz;
      sb_match <= sa_match;
      sb_live  <= sa_live;
    end
  end

  // stage c: offset from interpolated point
  logic signed [IW-1:0] sc_ex, sc_ey, sc_ez;
  logic                 sc_match, sc_live;

  always_ff @(posedge clk) begin
    if (rc && vb) begin
      sc_ex <= sb_ix - {{3{sb_px[C-1]}}, sb_px};
      sc_ey <= sb_iy - {{3{sb_py[C-1]}}, sb_py};
      sc_ez <= sb_iz - {{3{sb_pz[C-1]}}, sb_pz};
      sc_match <= sb_match;
      sc_live  <= sb_live;
    end
  end

  // stage d: squares and z window
  logic signed [QW2-1:0] sd_xx, sd_yy;
  logic [IW-1:0]         ez_mag;
  logic                  sd_zok, sd_match, sd_live;

  assign ez_mag = sc_ez[IW-1] ? $unsigned(-sc_ez) : $unsigned(sc_ez);

  always_ff @(posedge clk) begin
    if (rd && vc) begin
      sd_xx    <= sc_ex * sc_ex;
      sd_yy    <= sc_ey * sc_ey;
      sd_zok   <= ez_mag <= ztol;
      sd_match <= sc_match;
      sd_live  <= sc_live;
    end
  end

  // stage e: output register
  logic [QW2-1:0] dsum;
  assign dsum = $unsigned(sd_xx) + $unsigned(sd_yy);

  always_ff @(posedge clk) begin
    if (re && vd) begin
      match_waypoint <= sd_match;
      near_segment   <= sd_live && sd_zok && (dsum <= thr);
    end
  end

  assign out_valid = ve;

  `PSP_ASSERT_NEXT(a_out_kept, clk, rst, out_valid && out_stall, out_valid)
  `PSP_ASSERT_NEXT(a_in_lands, clk, rst, in_valid && !in_stall, v1)
  `PSP_ASSERT_IMPL(a_num_below_len, clk, rst, v4 && (s4_len != '0), s4_num < s4_len)
endmodule
